/* design/dlc_pkg.sv */
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared constants for the direct linear convolution block: field widths,
// parameter defaults and item mode codes.
// ----------------------------------------------------------------------------
package dlc_pkg;

    // parameter defaults
    localparam int MAX_TAPS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // field widths
    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 36;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // item modes carried on tuser
    localparam logic MODE_KERNEL = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // adder tree fan-in of the first reduction stage
    localparam int GROUP_SIZE = 4;

endpackage

/* design/direct_linear_convolution.sv */
// ----------------------------------------------------------------------------
// direct_linear_convolution
// Streaming full linear convolution of a sample vector with a loaded kernel.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser = 0 loads the next kernel word, tuser = 1 feeds
//   a sample. tlast on a kernel word completes the kernel; the next kernel word
//   then starts a new one. Words past MAX_TAPS are dropped.
//   tlast on a sample ends the vector: that sample gives its own output and
//   then kernel_length-1 tail outputs, after which the history is zero again.
//   m_axis carries one convolution output per transaction, saturated to 36
//   bits; tlast marks the last output of a vector.
// Timing:
//   an accepted sample passes the tap window, product, group-sum and output
//   registers to m_axis. One item is taken per cycle unless stalled; kernel
//   words produce nothing. A vector-ending sample holds s_axis_tready low
//   while its kernel_length-1 tail outputs shift zeros through the tap window,
//   one per cycle unless stalled. Taps multiply in parallel; a two-level tree sums.
// Reset:
//   aresetn (synchronous, active low) clears the kernel, the history and
//   every valid flag; the kernel counts as complete and empty.
// Stall:
//   when m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops in the same cycle.
// ----------------------------------------------------------------------------
module direct_linear_convolution #(
    parameter int MAX_TAPS    = dlc_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = dlc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input item stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dlc_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [15:0] value
    input  logic                          s_axis_tuser,  // [0] mode
    input  logic                          s_axis_tlast,  // last
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dlc_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [35:0] result, rest zero
    output logic                          m_axis_tlast   // final_res
);

    localparam int KW     = dlc_pkg::VALUE_W;
    localparam int SW     = (SAMPLE_BITS < dlc_pkg::VALUE_W) ? SAMPLE_BITS : dlc_pkg::VALUE_W;
    localparam int PW     = KW + SW;
    localparam int LENW   = $clog2(MAX_TAPS + 1);
    localparam int GS     = dlc_pkg::GROUP_SIZE;
    localparam int NGRP   = (MAX_TAPS + GS - 1) / GS;
    localparam int GW     = PW + $clog2(GS);
    localparam int SUMW   = GW + $clog2(NGRP) + 1;
    localparam int RW     = dlc_pkg::RESULT_W;
    localparam int PADW   = dlc_pkg::M_TDATA_W - RW;

    // kernel state
    logic signed [KW-1:0]   kernel_reg [MAX_TAPS];
    logic [LENW-1:0]        klen_reg;
    logic                   kdone_reg;

    // tail sequencing and history state
    logic [LENW-1:0]        tail_cnt_reg;
    logic                   hist_ok_reg;

    // pipeline stages
    logic signed [SW-1:0]   window_reg [MAX_TAPS];
    logic                   v1_reg, f1_reg;
    logic signed [PW-1:0]   prod_reg [MAX_TAPS];
    logic                   v2_reg, f2_reg;
    logic signed [GW-1:0]   grp_reg [NGRP];
    logic signed [GW-1:0]   grp_next [NGRP];
    logic                   v3_reg, f3_reg;
    logic signed [SUMW-1:0] total_sum;
    logic [RW-1:0]          result_sat;

    // output register
    logic                   m_valid_reg;
    logic [RW-1:0]          m_data_reg;
    logic                   m_last_reg;

    logic                   adv;
    logic                   s_acc;
    logic                   is_sample;
    logic signed [SW-1:0]   sample_in;

    // pipeline advances whenever the output register can take a result
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && (tail_cnt_reg == '0);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign is_sample     = (s_axis_tuser == dlc_pkg::MODE_SAMPLE);
    assign sample_in     = s_axis_tdata[SW-1:0];

    // kernel loading
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                kernel_reg[k] <= '0;
            end
            klen_reg  <= '0;
            kdone_reg <= 1'b1;
        end else if (s_acc && (s_axis_tuser == dlc_pkg::MODE_KERNEL)) begin
            if (kdone_reg) begin
                // first word of a new kernel clears the old taps
                for (int k = 0; k < MAX_TAPS; k++) begin
                    kernel_reg[k] <= (k == 0) ? s_axis_tdata[KW-1:0] : '0;
                end
                klen_reg <= LENW'(1);
            end else if (klen_reg < LENW'(MAX_TAPS)) begin
                for (int k = 0; k < MAX_TAPS; k++) begin
                    if (klen_reg == LENW'(k)) begin
                        kernel_reg[k] <= s_axis_tdata[KW-1:0];
                    end
                end
                klen_reg <= klen_reg + LENW'(1);
            end
            kdone_reg <= s_axis_tlast;
        end
    end

    // tap window stage: new sample or zero shift for tail outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            f1_reg       <= 1'b0;
            tail_cnt_reg <= '0;
            hist_ok_reg  <= 1'b0;
        end else if (adv) begin
            if (s_acc && is_sample) begin
                window_reg[0] <= sample_in;
                for (int k = 1; k < MAX_TAPS; k++) begin
                    window_reg[k] <= hist_ok_reg ? window_reg[k-1] : '0;
                end
                v1_reg      <= 1'b1;
                f1_reg      <= s_axis_tlast && (klen_reg <= LENW'(1));
                hist_ok_reg <= !s_axis_tlast;
                if (s_axis_tlast && (klen_reg > LENW'(1))) begin
                    tail_cnt_reg <= klen_reg - LENW'(1);
                end
            end else if (tail_cnt_reg != '0) begin
                window_reg[0] <= '0;
                for (int k = 1; k < MAX_TAPS; k++) begin
                    window_reg[k] <= window_reg[k-1];
                end
                v1_reg       <= 1'b1;
                f1_reg       <= (tail_cnt_reg == LENW'(1));
                tail_cnt_reg <= tail_cnt_reg - LENW'(1);
            end else begin
                v1_reg <= 1'b0;
                f1_reg <= 1'b0;
            end
        end
    end

    // product stage, all taps in parallel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
            for (int k = 0; k < MAX_TAPS; k++) begin
                prod_reg[k] <= PW'(kernel_reg[k]) * PW'(window_reg[k]);
            end
        end
    end

    // first level of the adder tree
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GS; j++) begin
                if (g * GS + j < MAX_TAPS) begin
                    grp_next[g] = grp_next[g] + GW'(prod_reg[g * GS + j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            f3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
            f3_reg <= f2_reg;
            for (int g = 0; g < NGRP; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    // final sum of the group totals
    always_comb begin
        total_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            total_sum = total_sum + SUMW'(grp_reg[g]);
        end
    end

    // saturate to the result width
    generate
        if (SUMW > RW) begin : g_sat
            logic ovf;
            assign ovf = (total_sum[SUMW-1:RW-1] != '0) && (total_sum[SUMW-1:RW-1] != '1);
            assign result_sat = !ovf ? total_sum[RW-1:0]
                              : (total_sum[SUMW-1] ? {1'b1, {(RW-1){1'b0}}}
                                                   : {1'b0, {(RW-1){1'b1}}});
        end else if (SUMW == RW) begin : g_exact
            assign result_sat = total_sum;
        end else begin : g_ext
            assign result_sat = {{(RW-SUMW){total_sum[SUMW-1]}}, total_sum};
        end
    endgenerate

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v3_reg;
            m_last_reg  <= f3_reg;
            m_data_reg  <= result_sat;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PADW{1'b0}}, m_data_reg};
    assign m_axis_tlast  = m_last_reg;

    // checks
    a_tail_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_cnt_reg != '0) |-> !s_axis_tready)
        else $error("input accepted while tail outputs pending");

    a_klen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        klen_reg <= LENW'(MAX_TAPS))
        else $error("kernel length beyond tap count");

    a_short_kernel_no_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_sample && s_axis_tlast && (klen_reg <= LENW'(1)))
        |=> (tail_cnt_reg == '0) && f1_reg)
        else $error("tail started for a kernel of at most one tap");

    a_kernel_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !is_sample) |=> !v1_reg)
        else $error("kernel word entered the result pipeline");

    a_tail_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (tail_cnt_reg == LENW'(1))) |=> (v1_reg && f1_reg && tail_cnt_reg == '0))
        else $error("final tail output not marked last");

endmodule

/* test/tb_direct_linear_convolution.sv */
// ----------------------------------------------------------------------------
// tb_direct_linear_convolution
// Self-checking bench for the streaming convolution block. A small scoreboard
// predicts every output from the accepted kernel words and samples, and
// compares each m_axis transaction field by field in order. Stimulus is a
// short directed run over the corner cases, then random kernel/vector
// sequences with random gaps and backpressure on both streams.
// ----------------------------------------------------------------------------
module tb_direct_linear_convolution;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_TAPS     = dlc_pkg::MAX_TAPS_DEF;
    localparam int     SAMPLE_BITS  = dlc_pkg::SAMPLE_BITS_DEF;
    localparam int     SAMP_W       = (SAMPLE_BITS < dlc_pkg::VALUE_W) ? SAMPLE_BITS
                                                                       : dlc_pkg::VALUE_W;
    localparam longint RES_MAX      = 64'sd34359738367;
    localparam longint RES_MIN      = -64'sd34359738368;
    localparam int     RANDOM_ITEMS = 64;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 400000;

    // one predicted output
    typedef struct {
        logic [dlc_pkg::RESULT_W-1:0] result;
        logic                         final_res;
    } conv_out_t;

    // kernel/history predictor and in-order output checker
    class conv_scoreboard;
        logic signed [dlc_pkg::VALUE_W-1:0] taps[MAX_TAPS];
        int unsigned                        tap_count;
        bit                                 kernel_done;
        logic signed [dlc_pkg::VALUE_W-1:0] history[MAX_TAPS];
        conv_out_t                          predicted_q[$];
        int unsigned                        error_count;

        function new();
            foreach (taps[i]) taps[i] = '0;
            foreach (history[i]) history[i] = '0;
            tap_count   = 0;
            kernel_done = 1'b1;
            error_count = 0;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // update the kernel or predict the outputs of one sample
        function void note_input(logic mode, logic [dlc_pkg::VALUE_W-1:0] value,
                                 logic last);
            logic signed [dlc_pkg::VALUE_W-1:0] win[MAX_TAPS];
            logic [dlc_pkg::VALUE_W-1:0]        shifted;
            longint                             acc;
            conv_out_t                          item;
            int                                 t;
            if (mode == dlc_pkg::MODE_KERNEL) begin
                if (kernel_done) begin
                    foreach (taps[i]) taps[i] = '0;
                    tap_count   = 0;
                    kernel_done = 1'b0;
                end
                if (tap_count < MAX_TAPS) begin
                    taps[tap_count] = $signed(value);
                    tap_count++;
                end
                if (last) kernel_done = 1'b1;
                return;
            end
            // sample: keep the low SAMP_W bits, sign-extended
            shifted = value << (dlc_pkg::VALUE_W - SAMP_W);
            win[0]  = $signed(shifted) >>> (dlc_pkg::VALUE_W - SAMP_W);
            for (int k = 1; k < MAX_TAPS; k++) win[k] = history[k-1];
            // main output, then the tail when the vector ends
            t = 0;
            while (t == 0 || (last && t < int'(tap_count))) begin
                acc = 0;
                for (int k = t; k < int'(tap_count); k++)
                    acc += longint'(taps[k]) * longint'(win[k-t]);
                if (acc > RES_MAX) acc = RES_MAX;
                if (acc < RES_MIN) acc = RES_MIN;
                item.result    = acc[dlc_pkg::RESULT_W-1:0];
                item.final_res = 1'b0;
                predicted_q    = {predicted_q, item};
                t++;
            end
            if (last) begin
                predicted_q[$].final_res = 1'b1;
                foreach (history[i]) history[i] = '0;
            end else begin
                for (int k = 0; k + 1 < MAX_TAPS; k++) history[k] = win[k];
            end
        endfunction

        // compare one output transaction with the oldest prediction
        function void check_result(logic [dlc_pkg::M_TDATA_W-1:0] tdata, logic tlast);
            conv_out_t exp_item;
            if (predicted_q.size() == 0) begin
                $error("unexpected output: result=0x%09h final_res=%0b",
                       tdata[dlc_pkg::RESULT_W-1:0], tlast);
                error_count++;
                return;
            end
            exp_item = predicted_q.pop_front();
            if (tdata[dlc_pkg::RESULT_W-1:0] !== exp_item.result) begin
                $error("result: expected 0x%09h, actual 0x%09h",
                       exp_item.result, tdata[dlc_pkg::RESULT_W-1:0]);
                error_count++;
            end
            if (tdata[dlc_pkg::M_TDATA_W-1:dlc_pkg::RESULT_W] !== '0) begin
                $error("tdata padding: expected 0x0, actual 0x%0h",
                       tdata[dlc_pkg::M_TDATA_W-1:dlc_pkg::RESULT_W]);
                error_count++;
            end
            if (tlast !== exp_item.final_res) begin
                $error("final_res: expected %0b, actual %0b", exp_item.final_res, tlast);
                error_count++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [dlc_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;   // [15:0] value
    logic                          s_axis_tuser  = 1'b0; // [0] mode
    logic                          s_axis_tlast  = 1'b0; // last
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [dlc_pkg::M_TDATA_W-1:0] m_axis_tdata;         // [35:0] result, rest zero
    logic                          m_axis_tlast;         // final_res

    conv_scoreboard scoreboard;
    bit             idle_on     = 1'b1;
    int unsigned    items_sent  = 0;
    int unsigned    cycle_count = 0;

    direct_linear_convolution #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // word with extra weight on the extremes
    function automatic logic [dlc_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return dlc_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // one input transaction, after an optional gap
    task automatic send_item(input logic mode, input logic [dlc_pkg::VALUE_W-1:0] value,
                             input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        scoreboard.note_input(mode, value, last);
        items_sent++;
    endtask

    // hold the sender off until every predicted output has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (scoreboard.pending() != 0);
    endtask

    // corner cases
    task automatic run_directed();
        // empty kernel after reset: zero outputs, no tail
        send_item(dlc_pkg::MODE_SAMPLE, 16'h7FFF, 1'b0);
        send_item(dlc_pkg::MODE_SAMPLE, 16'h8000, 1'b1);
        // oversize kernel of alternating extremes, extra words dropped
        for (int i = 0; i < MAX_TAPS + 1; i++)
            send_item(dlc_pkg::MODE_KERNEL, (i % 2) ? 16'h7FFF : 16'h8000, i == MAX_TAPS);
        // full-scale vector, last sample brings the longest tail
        send_item(dlc_pkg::MODE_SAMPLE, 16'h8000, 1'b0);
        send_item(dlc_pkg::MODE_SAMPLE, 16'h7FFF, 1'b0);
        send_item(dlc_pkg::MODE_SAMPLE, 16'h8000, 1'b1);
        // samples while a new kernel is still loading
        send_item(dlc_pkg::MODE_KERNEL, 16'h0001, 1'b0);
        send_item(dlc_pkg::MODE_SAMPLE, 16'h0005, 1'b0);
        send_item(dlc_pkg::MODE_KERNEL, 16'hFFFF, 1'b1);
        send_item(dlc_pkg::MODE_SAMPLE, 16'h0003, 1'b1);
    endtask

    // random kernel loads and vectors, with some noise items
    task automatic run_random();
        int n_taps;
        int n_samp;
        int mid;
        while (items_sent < RANDOM_ITEMS + 26) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_item(logic'($urandom_range(0, 1)), pick_word(),
                          logic'($urandom_range(0, 1)));
                continue;
            end
            // kernel load, short most of the time
            if ($urandom_range(0, 9) < 7) begin
                n_taps = ($urandom_range(0, 9) == 0) ? $urandom_range(12, MAX_TAPS + 4)
                                                     : $urandom_range(1, 5);
                mid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_taps - 1) : -1;
                for (int i = 0; i < n_taps; i++) begin
                    if (i == mid) send_item(dlc_pkg::MODE_SAMPLE, pick_word(), 1'b0);
                    send_item(dlc_pkg::MODE_KERNEL, pick_word(), i == n_taps - 1);
                end
            end
            // one vector
            n_samp = $urandom_range(1, 6);
            for (int i = 0; i < n_samp; i++)
                send_item(dlc_pkg::MODE_SAMPLE, pick_word(), i == n_samp - 1);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    // result side backpressure
    initial begin
        int n;
        forever begin
            n = idle_on ? $urandom_range(1, 12) : 60;
            m_axis_tready <= 1'b1;
            repeat (n) @(posedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            scoreboard.check_result(m_axis_tdata, m_axis_tlast);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** direct_linear_convolution: FAILED **");
            $finish;
        end
    end

    // main sequence
    initial begin
        scoreboard = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.pending() != 0) begin
            $error("%0d predicted outputs never arrived", scoreboard.pending());
            scoreboard.error_count++;
        end
        if (scoreboard.error_count == 0) begin
            $display("** direct_linear_convolution: PASSED **");
        end else begin
            $display("** direct_linear_convolution: FAILED **");
        end
        $finish;
    end

endmodule
